// ----- rtl/core/u8d_pkg.sv -----
// Package of the UTF-8 stream decoder: types, constants and the decode function.
package u8d_pkg;

    typedef logic [7:0] byte_t;
    typedef byte_t [3:0] window_t;   // entry 0 is the front of the window

    typedef enum logic [1:0] {
        STAT_CP  = 2'd0,
        STAT_ERR = 2'd1,
        STAT_END = 2'd2
    } stat_t;

    localparam logic [7:0]  CONT_PATTERN = 8'h2a;   // expected continuation tag bits
    localparam logic [13:0] SURR_HIGH    = 14'h1b;  // value[24:11] of a surrogate
    localparam logic [24:0] FLOOR_TWO    = 25'd128;
    localparam logic [24:0] FLOOR_THREE  = 25'd2048;
    localparam logic [24:0] FLOOR_FOUR   = 25'd65536;

    typedef struct packed {
        logic        ok;
        logic [2:0]  n;
        logic [20:0] cp;
    } dec_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_byte;
        logic drain_step;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic error_seen;
        logic fill_zero;
        logic out_free;
    } dp_status_t;

    function automatic dec_t decode(window_t w);
        logic [2:0]  n;
        logic [6:0]  lead;
        logic [24:0] v25;
        logic [24:0] v;
        logic        below;
        logic [7:0]  bad;
        logic [7:0]  bad_kept;
        dec_t        r;
        priority if (!w[0][7])
            n = 3'd1;
        else if (w[0][7:5] == 3'b110)
            n = 3'd2;
        else if (w[0][7:4] == 4'b1110)
            n = 3'd3;
        else if (w[0][7:3] == 5'b11110)
            n = 3'd4;
        else
            n = 3'd0;
        unique case (n)
            3'd1:    lead = w[0][6:0];
            3'd2:    lead = {2'b00, w[0][4:0]};
            3'd3:    lead = {3'b000, w[0][3:0]};
            3'd4:    lead = {4'b0000, w[0][2:0]};
            default: lead = 7'd0;
        endcase
        v25 = {lead, w[1][5:0], w[2][5:0], w[3][5:0]};
        unique case (n)
            3'd1:
            begin
                v     = v25 >> 18;
                below = 1'b0;
            end
            3'd2:
            begin
                v     = v25 >> 12;
                below = (v < FLOOR_TWO);
            end
            3'd3:
            begin
                v     = v25 >> 6;
                below = (v < FLOOR_THREE);
            end
            3'd4:
            begin
                v     = v25;
                below = (v < FLOOR_FOUR);
            end
            default:
            begin
                v     = v25;
                below = 1'b1;
            end
        endcase
        bad = {below, (v[24:11] == SURR_HIGH), w[1][7:6], w[2][7:6], w[3][7:6]}
              ^ CONT_PATTERN;
        // Only the checks that apply to this length are kept.
        unique case (n)
            3'd1:    bad_kept = bad >> 6;
            3'd2:    bad_kept = bad >> 4;
            3'd3:    bad_kept = bad >> 2;
            default: bad_kept = bad;
        endcase
        r.ok = (n != 3'd0) && (bad_kept == 8'd0);
        r.n  = n;
        r.cp = v[20:0];
        return r;
    endfunction

endpackage

// ----- rtl/core/u8d_ctrl.sv -----
// Controller of the UTF-8 stream decoder: accepts words and sequences the end-of-stream drain.
module u8d_ctrl
    import u8d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tuser,
    output logic       s_tready,
    input  dp_status_t status,
    output cmd_t       cmd
);

    typedef enum logic {
        ST_RUN,
        ST_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_RUN) && status.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next     = state_reg;
        cmd.load_byte  = 1'b0;
        cmd.drain_step = 1'b0;
        cmd.finish     = 1'b0;
        unique case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    if (!s_tuser)
                        cmd.load_byte = !status.error_seen;
                    else if (status.error_seen || status.fill_zero)
                        cmd.finish = 1'b1;
                    else
                        state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.out_free)
                begin
                    if (status.fill_zero)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_RUN;
                    end
                    else
                        cmd.drain_step = 1'b1;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_RUN;
        else
            state_reg <= state_next;
    end

endmodule

// ----- rtl/core/u8d_datapath.sv -----
// Datapath of the UTF-8 stream decoder: window, fill count, decoder and output register.
module u8d_datapath
    import u8d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  logic [7:0]  s_tdata,
    input  logic        m_tready,
    output dp_status_t  status,
    output logic        m_tvalid,
    output logic [23:0] m_tdata,
    output logic        m_tlast,
    output logic [1:0]  m_tuser
);

    window_t     win_reg;
    window_t     win_next;
    logic [2:0]  fill_reg;
    logic [2:0]  fill_next;
    logic        err_reg;
    logic        err_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [20:0] out_cp_reg;
    logic [20:0] out_cp_next;
    stat_t       out_stat_reg;
    stat_t       out_stat_next;
    logic        out_last_reg;
    logic        out_last_next;

    window_t     win_app;
    window_t     dec_src;
    dec_t        dec;
    logic [2:0]  fill_dec;
    logic [2:0]  fill_left;
    logic        out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        win_app                = win_reg;
        win_app[fill_reg[1:0]] = s_tdata;
    end

    // A loaded word is decoded together with the window it completes.
    assign dec_src   = cmd.load_byte ? win_app : win_reg;
    assign dec       = decode(dec_src);
    assign fill_dec  = cmd.load_byte ? 3'd4 : fill_reg;
    assign fill_left = (fill_dec > dec.n) ? (fill_dec - dec.n) : 3'd0;

    always_comb
    begin
        win_next       = win_reg;
        fill_next      = fill_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_cp_next    = out_cp_reg;
        out_stat_next  = out_stat_reg;
        out_last_next  = out_last_reg;
        priority if (cmd.finish)
        begin
            win_next       = '0;
            fill_next      = 3'd0;
            err_next       = 1'b0;
            out_valid_next = 1'b1;
            out_cp_next    = 21'd0;
            out_stat_next  = STAT_END;
            out_last_next  = 1'b1;
        end
        else if (cmd.load_byte && (fill_reg != 3'd3))
        begin
            win_next  = win_app;
            fill_next = fill_reg + 3'd1;
        end
        else if (cmd.load_byte || cmd.drain_step)
        begin
            out_valid_next = 1'b1;
            out_last_next  = cmd.load_byte;
            if (dec.ok)
            begin
                win_next      = dec_src >> {dec.n, 3'b000};
                fill_next     = fill_left;
                out_cp_next   = dec.cp;
                out_stat_next = STAT_CP;
            end
            else
            begin
                // An error during the drain empties the window so the end word follows.
                win_next      = cmd.load_byte ? win_app : '0;
                fill_next     = cmd.load_byte ? 3'd4 : 3'd0;
                err_next      = 1'b1;
                out_cp_next   = 21'd0;
                out_stat_next = STAT_ERR;
            end
        end
        else
        begin
            out_valid_next = out_valid_reg && !m_tready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= '0;
            fill_reg      <= 3'd0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            win_reg       <= win_next;
            fill_reg      <= fill_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_cp_reg   <= out_cp_next;
        out_stat_reg <= out_stat_next;
        out_last_reg <= out_last_next;
    end

    assign status.error_seen = err_reg;
    assign status.fill_zero  = (fill_reg == 3'd0);
    assign status.out_free   = out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_cp_reg};
    assign m_tuser  = out_stat_reg;
    assign m_tlast  = out_last_reg;

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 3'd4)
        else $error("fill count out of range");

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (fill_reg == 3'd0) && !err_reg && m_tvalid && m_tlast
                       && (out_stat_reg == STAT_END))
        else $error("end word did not return the block to reset");

    a_drain_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drain_step |=> m_tvalid && !m_tlast && (out_stat_reg != STAT_END))
        else $error("drain word marked last or end");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg && !cmd.finish) |=> err_reg)
        else $error("error flag dropped without end of stream");

endmodule

// ----- rtl/core/utf8_stream_decoder.sv -----
// Result: registered, and presented in the cycle after the input word that causes it.
// Rate: one word per cycle unless m_tready stalls; output frees in the cycle it is taken.
// End of stream: the flush word, then one word per remaining code point (at most three)
// from the decode unit, then the end word; no input word is taken during the drain.
// Reset: asynchronous, active low; clears the window, fill count, error flag and m_tvalid.
// Top level of the UTF-8 stream decoder.
module utf8_stream_decoder
    import u8d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast    // last word caused by the input word
);

    cmd_t       cmd;
    dp_status_t status;

    u8d_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    u8d_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
